@@ design/rgc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgc_pkg
// shared types, constants and link decode for the room graph connectivity check
// ----------------------------------------------------------------------------
package rgc_pkg;

    localparam int LINKS_PER_NODE = 4;
    localparam int LINK_W         = 5;
    localparam int IDX_W          = 4;
    localparam int ROW_W          = LINKS_PER_NODE * LINK_W;
    // wide enough to hold any node count up to 64
    localparam int CNT_W          = 7;

    typedef logic [LINK_W-1:0] t_link;
    typedef logic [ROW_W-1:0]  t_row;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_CHECK = 1'b1
    } t_cmd;

    // link names a real node: not negative and below the node count
    function automatic logic link_in_range(t_link link, logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] v;
        v = CNT_W'(link[LINK_W-2:0]);
        return !link[LINK_W-1] && (v < count);
    endfunction

endpackage

@@ design/rgc_node_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgc_node_table
// neighbor link memory with per-entry valid bits and decoded read port
// ----------------------------------------------------------------------------
module rgc_node_table
    import rgc_pkg::*;
#(
    parameter int NODE_COUNT = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [$clog2(NODE_COUNT)-1:0]     i_waddr,
    input  t_row                              i_wdata,
    input  logic                              i_re,
    input  logic [$clog2(NODE_COUNT)-1:0]     i_raddr,
    output logic [LINKS_PER_NODE-1:0]         o_link_ok,
    output logic [$clog2(NODE_COUNT)-1:0]     o_link_tgt [LINKS_PER_NODE]
);

    localparam int NODE_W = $clog2(NODE_COUNT);

    t_row                  m_row [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_vld;
    t_row                  r_rd_row;
    logic                  r_rd_vld;

    // entry written since reset, otherwise reads as all links none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            m_row[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_row <= m_row[i_raddr];
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    always_comb begin
        for (int k = 0; k < LINKS_PER_NODE; k++) begin
            t_link            lk;
            logic [CNT_W-1:0] ext;
            lk            = r_rd_row[k*LINK_W +: LINK_W];
            ext           = CNT_W'(lk[LINK_W-2:0]);
            o_link_ok[k]  = r_rd_vld && link_in_range(lk, CNT_W'(NODE_COUNT));
            o_link_tgt[k] = ext[NODE_W-1:0];
        end
    end

endmodule

@@ design/room_graph_connectivity_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// room_graph_connectivity_check
// node table with depth-first reachability check over the neighbor links
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  input    in         i_valid / o_stall   i_command, i_node_index, i_node_active,
//                                          i_link_0 .. i_link_3
//  output   out        o_valid / i_stall   o_all_connected
//
//  a load item gives no result
//  a check item runs a scan for the start node, then per reached node a stack read,
//  a table read and one link per cycle through the single read port of the
//  neighbor table, then a scan of the visited marks
//  o_stall is high while a check runs; loads are taken while a result waits
//  reset is synchronous, active low; it clears flags, valid bits and control
// ----------------------------------------------------------------------------
module room_graph_connectivity_check
    import rgc_pkg::*;
#(
    parameter int NODE_COUNT = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_command,
    input  logic [IDX_W-1:0]         i_node_index,
    input  logic                     i_node_active,
    input  logic signed [LINK_W-1:0] i_link_0,
    input  logic signed [LINK_W-1:0] i_link_1,
    input  logic signed [LINK_W-1:0] i_link_2,
    input  logic signed [LINK_W-1:0] i_link_3,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_all_connected
);

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int DEPTH_W = $clog2(NODE_COUNT + 1);
    localparam logic [NODE_W-1:0] LAST_IDX = NODE_W'(NODE_COUNT - 1);
    localparam logic [1:0]        LAST_LINK = 2'(LINKS_PER_NODE - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SEED,
        S_POP,
        S_FETCH,
        S_LINK,
        S_CHECK,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [NODE_COUNT-1:0] r_active;
    logic [NODE_COUNT-1:0] r_visited;
    logic [NODE_W-1:0]     r_idx;
    logic [NODE_W-1:0]     r_start;
    logic [DEPTH_W-1:0]    r_depth;
    logic [1:0]            r_k;
    logic                  r_ok;
    logic                  r_out_valid;
    logic                  r_out_data;

    // walk stack memory, registered read
    logic [NODE_W-1:0] m_stack [NODE_COUNT];
    logic [NODE_W-1:0] r_stack_rd;

    logic                  in_take;
    logic                  load_ok;
    logic [CNT_W-1:0]      idx_ext;
    logic [NODE_W-1:0]     load_addr;
    logic                  stk_we;
    logic [NODE_W-1:0]     stk_waddr;
    logic [NODE_W-1:0]     stk_wdata;
    logic                  stk_re;
    logic [DEPTH_W-1:0]    depth_dec;
    logic                  tab_we;
    logic                  tab_re;
    logic [LINKS_PER_NODE-1:0] link_ok;
    logic [NODE_W-1:0]     link_tgt [LINKS_PER_NODE];
    logic                  cur_ok;
    logic [NODE_W-1:0]     cur_tgt;
    logic                  push;

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_all_connected = r_out_data;

    assign in_take   = i_valid && (r_state == S_IDLE);
    // loads aimed past the table are dropped
    assign idx_ext   = CNT_W'(i_node_index);
    assign load_ok   = idx_ext < CNT_W'(NODE_COUNT);
    assign load_addr = idx_ext[NODE_W-1:0];
    assign tab_we    = in_take && (t_cmd'(i_command) == CMD_LOAD) && load_ok;
    assign tab_re    = (r_state == S_FETCH);
    assign depth_dec = r_depth - 1'b1;

    // current link of the node being expanded
    assign cur_ok  = link_ok[r_k];
    assign cur_tgt = link_tgt[r_k];
    // push only unmarked targets, so every node enters the stack once at most
    assign push    = (r_state == S_LINK) && cur_ok && !r_visited[cur_tgt];

    always_comb begin
        stk_we    = 1'b0;
        stk_waddr = r_depth[NODE_W-1:0];
        stk_wdata = cur_tgt;
        if (r_state == S_SEED) begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = r_start;
        end else if (push) begin
            stk_we = 1'b1;
        end
    end

    assign stk_re = (r_state == S_POP) && (r_depth != '0);

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            m_stack[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stack_rd <= m_stack[depth_dec[NODE_W-1:0]];
        end
    end

    rgc_node_table #(
        .NODE_COUNT (NODE_COUNT)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (tab_we),
        .i_waddr    (load_addr),
        .i_wdata    ({i_link_3, i_link_2, i_link_1, i_link_0}),
        .i_re       (tab_re),
        .i_raddr    (r_stack_rd),
        .o_link_ok  (link_ok),
        .o_link_tgt (link_tgt)
    );

    // sequencer: state, flags, walk counters and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_visited   <= '0;
            r_idx       <= '0;
            r_start     <= '0;
            r_depth     <= '0;
            r_k         <= '0;
            r_ok        <= 1'b1;
            r_out_valid <= 1'b0;
            r_out_data  <= 1'b0;
        end else begin
            // result taken downstream, the done state handles its own handoff
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        if (t_cmd'(i_command) == CMD_CHECK) begin
                            r_visited <= '0;
                            r_idx     <= '0;
                            r_start   <= '0;
                            r_state   <= S_SCAN;
                        end else if (load_ok) begin
                            r_active[load_addr] <= i_node_active;
                        end
                    end
                end
                S_SCAN: begin
                    // highest active node wins, node 0 if none
                    if (r_active[r_idx]) begin
                        r_start <= r_idx;
                    end
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_SEED;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SEED: begin
                    r_visited[r_start] <= 1'b1;
                    r_depth            <= DEPTH_W'(1);
                    r_state            <= S_POP;
                end
                S_POP: begin
                    if (r_depth == '0) begin
                        r_idx   <= '0;
                        r_ok    <= 1'b1;
                        r_state <= S_CHECK;
                    end else begin
                        r_depth <= depth_dec;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_k     <= '0;
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    if (push) begin
                        r_visited[cur_tgt] <= 1'b1;
                        r_depth            <= r_depth + 1'b1;
                    end
                    if (r_k == LAST_LINK) begin
                        r_state <= S_POP;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_CHECK: begin
                    if (r_active[r_idx] && !r_visited[r_idx]) begin
                        r_ok <= 1'b0;
                    end
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    // wait for a previous result to leave
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_ok;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/rgc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgc_checker
// port-level checks for the room graph connectivity check, bound to the top
// ----------------------------------------------------------------------------
module rgc_checker
    import rgc_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic                     i_command,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic                     o_all_connected
);

    logic take_load;
    logic take_check;

    assign take_load  = i_valid && !o_stall && (t_cmd'(i_command) == CMD_LOAD);
    assign take_check = i_valid && !o_stall && (t_cmd'(i_command) == CMD_CHECK);

    // no result is shown in the cycle after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_all_connected))
        else $error("stalled result changed");

    // a load item never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_load && !o_valid |=> !o_valid)
        else $error("result after load item");

    // an accepted check keeps the input side busy while it walks
    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_check |=> o_stall)
        else $error("input not stalled during check");

endmodule

bind room_graph_connectivity_check rgc_checker u_rgc_checker (.*);
